>>> hdl/ltc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ltc_pkg
// shared types, scanner state codes, class codes and the recognizer tables
// ----------------------------------------------------------------------------
package ltc_pkg;

  localparam int CharWidth  = 8;
  localparam int StateWidth = 4;
  localparam int ClassWidth = 3;

  // scanner states
  localparam logic [StateWidth-1:0] ST_START     = 4'd0;
  localparam logic [StateWidth-1:0] ST_ONE_SP    = 4'd1;
  localparam logic [StateWidth-1:0] ST_LEAD_SP   = 4'd2;
  localparam logic [StateWidth-1:0] ST_SIGN      = 4'd3;
  localparam logic [StateWidth-1:0] ST_OTHER_X   = 4'd4;
  localparam logic [StateWidth-1:0] ST_X_TRAIL   = 4'd5;
  localparam logic [StateWidth-1:0] ST_INT_D     = 4'd6;
  localparam logic [StateWidth-1:0] ST_INT_TRAIL = 4'd7;
  localparam logic [StateWidth-1:0] ST_DOT       = 4'd8;
  localparam logic [StateWidth-1:0] ST_FRAC      = 4'd9;
  localparam logic [StateWidth-1:0] ST_F         = 4'd10;
  localparam logic [StateWidth-1:0] ST_F_TRAIL   = 4'd11;
  localparam logic [StateWidth-1:0] ST_D_TRAIL   = 4'd12;
  localparam logic [StateWidth-1:0] ST_DEAD      = 4'd13;

  // literal classes
  localparam logic [ClassWidth-1:0] CLS_NONE   = 3'd0;
  localparam logic [ClassWidth-1:0] CLS_CHAR   = 3'd1;
  localparam logic [ClassWidth-1:0] CLS_INT    = 3'd2;
  localparam logic [ClassWidth-1:0] CLS_FLOAT  = 3'd3;
  localparam logic [ClassWidth-1:0] CLS_DOUBLE = 3'd4;

  // characters of interest
  localparam logic [CharWidth-1:0] CH_SPACE = 8'h20;
  localparam logic [CharWidth-1:0] CH_DOT   = 8'h2E;
  localparam logic [CharWidth-1:0] CH_F     = 8'h66;
  localparam logic [CharWidth-1:0] CH_MINUS = 8'h2D;
  localparam logic [CharWidth-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CharWidth-1:0] CH_ZERO  = 8'h30;
  localparam logic [CharWidth-1:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [CharWidth-1:0] ch;
    logic                 last_char;
  } item_t;

  function automatic logic [StateWidth-1:0] next_state(
    input logic [StateWidth-1:0] s,
    input logic [CharWidth-1:0]  c
  );
    logic sp;
    logic dg;
    logic sg;
    logic [StateWidth-1:0] ns;
    sp = (c == CH_SPACE);
    dg = (c >= CH_ZERO) && (c <= CH_NINE);
    sg = (c == CH_PLUS) || (c == CH_MINUS);
    case (s)
      ST_START, ST_ONE_SP, ST_LEAD_SP: begin
        if (sp)      ns = (s == ST_START) ? ST_ONE_SP : ST_LEAD_SP;
        else if (dg) ns = ST_INT_D;
        else if (sg) ns = ST_SIGN;
        else         ns = ST_OTHER_X;
      end
      ST_SIGN: begin
        if (dg)      ns = ST_INT_D;
        else if (sp) ns = ST_X_TRAIL;
        else         ns = ST_DEAD;
      end
      ST_OTHER_X, ST_X_TRAIL: begin
        ns = sp ? ST_X_TRAIL : ST_DEAD;
      end
      ST_INT_D: begin
        if (dg)               ns = ST_INT_D;
        else if (c == CH_DOT) ns = ST_DOT;
        else if (sp)          ns = ST_INT_TRAIL;
        else                  ns = ST_DEAD;
      end
      ST_INT_TRAIL: begin
        ns = sp ? ST_INT_TRAIL : ST_DEAD;
      end
      ST_DOT: begin
        ns = dg ? ST_FRAC : ST_DEAD;
      end
      ST_FRAC: begin
        if (dg)             ns = ST_FRAC;
        else if (c == CH_F) ns = ST_F;
        else if (sp)        ns = ST_D_TRAIL;
        else                ns = ST_DEAD;
      end
      ST_F, ST_F_TRAIL: begin
        ns = sp ? ST_F_TRAIL : ST_DEAD;
      end
      ST_D_TRAIL: begin
        ns = sp ? ST_D_TRAIL : ST_DEAD;
      end
      default: begin
        ns = ST_DEAD;
      end
    endcase
    return ns;
  endfunction

  function automatic logic [ClassWidth-1:0] class_of(input logic [StateWidth-1:0] s);
    logic [ClassWidth-1:0] cls;
    case (s)
      ST_ONE_SP, ST_SIGN, ST_OTHER_X, ST_X_TRAIL: cls = CLS_CHAR;
      ST_INT_D, ST_INT_TRAIL:                     cls = CLS_INT;
      ST_FRAC, ST_D_TRAIL:                        cls = CLS_DOUBLE;
      ST_F, ST_F_TRAIL:                           cls = CLS_FLOAT;
      default:                                    cls = CLS_NONE;
    endcase
    return cls;
  endfunction

endpackage
`default_nettype wire

>>> hdl/literal_type_classifier.sv
`timescale 1ns / 1ps
`default_nettype none
// path: the last character of a string is held in the input register, then
//   its class is registered in the result register
// throughput: one character per cycle, set by the single state register that
//   takes one transition per cycle; a last character waits on a stalled result
// reset: synchronous, active high; clears both stages and returns the
//   recognizer to start of string
// ----------------------------------------------------------------------------
// literal_type_classifier
// classifies a character string as char, int, float, double or none
// ----------------------------------------------------------------------------
module literal_type_classifier (
  input  wire logic       clk,
  input  wire logic       rst,
  // character stream in
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] ch
  input  wire logic       s_tlast,   // last_char
  // class stream out
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata    // [2:0] literal_class, [7:3] zero
);
  import ltc_pkg::*;

  item_t                 in_item;
  item_t                 item;
  logic                  item_valid;
  logic                  out_free;
  logic                  step;
  logic [ClassWidth-1:0] literal_class;
  logic [ClassWidth-1:0] out_class;

  assign in_item.ch        = s_tdata;
  assign in_item.last_char = s_tlast;

  // a character that ends no string never waits on the output side;
  // the last one moves only when the result register can take its class
  assign step = item_valid && (!item.last_char || out_free);

  ltc_input_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_item    (in_item),
    .in_ready   (s_tready),
    .take       (step),
    .item_valid (item_valid),
    .item       (item)
  );

  // state transition and class lookup of the registered character
  ltc_scanner u_scan (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .item          (item),
    .literal_class (literal_class)
  );

  // only the last character of a string produces a result transfer
  ltc_output_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (step && item.last_char),
    .literal_class (literal_class),
    .free          (out_free),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_class     (out_class)
  );

  assign m_tdata = {{(8 - ClassWidth){1'b0}}, out_class};

endmodule
`default_nettype wire

>>> hdl/ltc_input_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ltc_input_stage
// input register for one character, refilled in the cycle it drains
// ----------------------------------------------------------------------------
module ltc_input_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire ltc_pkg::item_t in_item,
  output logic               in_ready,
  input  wire logic          take,
  output logic               item_valid,
  output ltc_pkg::item_t     item
);
  import ltc_pkg::*;

  assign in_ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule
`default_nettype wire

>>> hdl/ltc_scanner.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ltc_scanner
// recognizer state register and one transition per character
// ----------------------------------------------------------------------------
module ltc_scanner (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        step,
  input  wire ltc_pkg::item_t              item,
  output logic [ltc_pkg::ClassWidth-1:0]   literal_class
);
  import ltc_pkg::*;

  logic [StateWidth-1:0] scan_state;
  logic [StateWidth-1:0] scan_state_next;

  assign scan_state_next = next_state(scan_state, item.ch);
  assign literal_class   = class_of(scan_state_next);

  // back to start of string after the last character
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state <= ST_START;
    end else if (step) begin
      scan_state <= item.last_char ? ST_START : scan_state_next;
    end
  end

endmodule
`default_nettype wire

>>> hdl/ltc_output_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ltc_output_stage
// result register holding one class until the downstream side takes it
// ----------------------------------------------------------------------------
module ltc_output_stage (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      load,
  input  wire logic [ltc_pkg::ClassWidth-1:0] literal_class,
  output logic                           free,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [ltc_pkg::ClassWidth-1:0] out_class
);
  import ltc_pkg::*;

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      out_class <= literal_class;
    end
  end

endmodule
`default_nettype wire

>>> hdl/ltc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ltc_checker
// port-level checks of the classifier, bound to the top level
// ----------------------------------------------------------------------------
module ltc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tvalid,
  input wire logic       s_tready,
  input wire logic [7:0] s_tdata,
  input wire logic       s_tlast,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata
);

  // a stalled character transfer holds its data and last mark
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast))
    else $error("character changed while stalled");

  // a stalled result transfer holds its class
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // only the five class codes ever leave
  a_class_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata <= 8'd4)
    else $error("class code out of range");

  // input side stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output backpressure");

  // nothing leaves right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind literal_type_classifier ltc_checker u_ltc_checker (.*);
`default_nettype wire

>>> bench/tb_literal_type_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_literal_type_classifier
// drives character strings through the classifier and checks every class
// result against a bench scanner model or typed row: a fixed table of corner
// strings first, then randomly built strings, mostly well-formed numbers and
// chars with some broken and noise strings, with random gaps on both streams
// ----------------------------------------------------------------------------
module tb_literal_type_classifier;
  import ltc_pkg::*;

  localparam int RandomChars = 450;
  localparam int MaxReports  = 10;
  localparam int DirRows     = 25;

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;   // [7:0] ch
  logic       s_tlast;   // last_char
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;   // [2:0] literal_class, [7:3] zero

  literal_type_classifier u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // kinds of random strings
  typedef enum int {
    GEN_CHAR,
    GEN_INT,
    GEN_FLOAT,
    GEN_DOUBLE,
    GEN_SPACES,
    GEN_BROKEN,
    GEN_NOISE
  } gen_kind_t;

  // one row of the directed table; typed rows carry a hand-written class
  typedef struct packed {
    logic [CharWidth-1:0]  ch;
    logic                  last;
    logic                  typed;
    logic [ClassWidth-1:0] cls;
  } dir_row_t;

  // corner strings; untyped rows fall back to the scanner model
  dir_row_t dir_tab [DirRows] = '{
    // single space is a char
    '{CH_SPACE, 1'b1, 1'b1, CLS_CHAR},
    // two spaces only is none
    '{CH_SPACE, 1'b0, 1'b0, CLS_NONE},
    '{CH_SPACE, 1'b1, 1'b1, CLS_NONE},
    // byte extremes are ordinary characters
    '{8'h00,    1'b1, 1'b1, CLS_CHAR},
    '{8'hFF,    1'b1, 1'b1, CLS_CHAR},
    // digit extremes
    '{CH_NINE,  1'b1, 1'b1, CLS_INT},
    '{CH_ZERO,  1'b1, 1'b1, CLS_INT},
    // signed int
    '{CH_MINUS, 1'b0, 1'b0, CLS_NONE},
    '{8'h37,    1'b1, 1'b0, CLS_NONE},
    // lone sign followed by a space is a char
    '{CH_PLUS,  1'b0, 1'b0, CLS_NONE},
    '{CH_SPACE, 1'b1, 1'b1, CLS_CHAR},
    // 1.5f
    '{8'h31,    1'b0, 1'b0, CLS_NONE},
    '{CH_DOT,   1'b0, 1'b0, CLS_NONE},
    '{8'h35,    1'b0, 1'b0, CLS_NONE},
    '{CH_F,     1'b1, 1'b1, CLS_FLOAT},
    // 3.2
    '{8'h33,    1'b0, 1'b0, CLS_NONE},
    '{CH_DOT,   1'b0, 1'b0, CLS_NONE},
    '{8'h32,    1'b1, 1'b1, CLS_DOUBLE},
    // dot with no fraction is none
    '{8'h34,    1'b0, 1'b0, CLS_NONE},
    '{CH_DOT,   1'b1, 1'b1, CLS_NONE},
    // two letters is none
    '{8'h61,    1'b0, 1'b0, CLS_NONE},
    '{8'h62,    1'b1, 1'b1, CLS_NONE},
    // char with spaces around it
    '{CH_SPACE, 1'b0, 1'b0, CLS_NONE},
    '{8'h78,    1'b0, 1'b0, CLS_NONE},
    '{CH_SPACE, 1'b1, 1'b1, CLS_CHAR}
  };

  // scanner model state and the classes still to come out
  logic [StateWidth-1:0] scan_state;
  logic [ClassWidth-1:0] class_due_q [$];

  // string under construction for the random part
  logic [CharWidth-1:0] str_q [$];

  int  err_count;
  int  chars_sent;
  int  strings_sent;
  int  results_seen;
  int  class_hits [5];
  bit  src_burst;

  // ---------------------------------------------------------------------------
  // scanner model
  // ---------------------------------------------------------------------------
  function automatic logic [StateWidth-1:0] scan_step(
    input logic [StateWidth-1:0] st,
    input logic [CharWidth-1:0]  c
  );
    logic is_sp;
    logic is_dg;
    logic is_sg;
    logic [StateWidth-1:0] nxt;
    is_sp = (c == CH_SPACE);
    is_dg = (c >= CH_ZERO) && (c <= CH_NINE);
    is_sg = (c == CH_PLUS) || (c == CH_MINUS);
    nxt   = ST_DEAD;
    case (st)
      ST_START: begin
        if (is_sp)      nxt = ST_ONE_SP;
        else if (is_dg) nxt = ST_INT_D;
        else if (is_sg) nxt = ST_SIGN;
        else            nxt = ST_OTHER_X;
      end
      ST_ONE_SP, ST_LEAD_SP: begin
        if (is_sp)      nxt = ST_LEAD_SP;
        else if (is_dg) nxt = ST_INT_D;
        else if (is_sg) nxt = ST_SIGN;
        else            nxt = ST_OTHER_X;
      end
      ST_SIGN: begin
        if (is_dg)      nxt = ST_INT_D;
        else if (is_sp) nxt = ST_X_TRAIL;
      end
      ST_OTHER_X, ST_X_TRAIL: begin
        if (is_sp) nxt = ST_X_TRAIL;
      end
      ST_INT_D: begin
        if (is_dg)            nxt = ST_INT_D;
        else if (c == CH_DOT) nxt = ST_DOT;
        else if (is_sp)       nxt = ST_INT_TRAIL;
      end
      ST_INT_TRAIL: begin
        if (is_sp) nxt = ST_INT_TRAIL;
      end
      ST_DOT: begin
        if (is_dg) nxt = ST_FRAC;
      end
      ST_FRAC: begin
        if (is_dg)          nxt = ST_FRAC;
        else if (c == CH_F) nxt = ST_F;
        else if (is_sp)     nxt = ST_D_TRAIL;
      end
      ST_F, ST_F_TRAIL: begin
        if (is_sp) nxt = ST_F_TRAIL;
      end
      ST_D_TRAIL: begin
        if (is_sp) nxt = ST_D_TRAIL;
      end
      default: begin
        nxt = ST_DEAD;
      end
    endcase
    return nxt;
  endfunction

  function automatic logic [ClassWidth-1:0] class_for_state(input logic [StateWidth-1:0] st);
    logic [ClassWidth-1:0] cls;
    cls = CLS_NONE;
    if (st == ST_ONE_SP || st == ST_SIGN || st == ST_OTHER_X || st == ST_X_TRAIL)
      cls = CLS_CHAR;
    else if (st == ST_INT_D || st == ST_INT_TRAIL)
      cls = CLS_INT;
    else if (st == ST_F || st == ST_F_TRAIL)
      cls = CLS_FLOAT;
    else if (st == ST_FRAC || st == ST_D_TRAIL)
      cls = CLS_DOUBLE;
    return cls;
  endfunction

  // mostly short gaps, now and then a long one, none at all in a burst
  function automatic int idle_len(input bit burst);
    int roll;
    roll = $urandom_range(0, 99);
    if (burst)     return 0;
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // source side: one character transfer, then advance the model
  // ---------------------------------------------------------------------------
  task automatic send_char(
    input logic [CharWidth-1:0]  c,
    input logic                  last,
    input logic                  typed,
    input logic [ClassWidth-1:0] cls
  );
    int gap;
    logic [StateWidth-1:0] nxt;
    gap = idle_len(src_burst);
    repeat (gap) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= last;
    // tready is read before the edge updates land
    do @(posedge clk); while (!s_tready);
    chars_sent++;
    nxt = scan_step(scan_state, c);
    if (last) begin
      class_due_q.push_back(typed ? cls : class_for_state(nxt));
      scan_state = ST_START;
      strings_sent++;
    end else begin
      scan_state = nxt;
    end
  endtask

  function automatic logic [CharWidth-1:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // any byte that is neither a space nor a digit
  function automatic logic [CharWidth-1:0] rand_symbol();
    logic [CharWidth-1:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_SPACE || (c >= CH_ZERO && c <= CH_NINE));
    return c;
  endfunction

  task automatic add_spaces(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) str_q.push_back(CH_SPACE);
  endtask

  task automatic add_number(input bit frac, input bit suffix);
    add_spaces(0, 2);
    case ($urandom_range(0, 3))
      0: str_q.push_back(CH_PLUS);
      1: str_q.push_back(CH_MINUS);
      default: ;
    endcase
    repeat ($urandom_range(1, 4)) str_q.push_back(rand_digit());
    if (frac) begin
      str_q.push_back(CH_DOT);
      repeat ($urandom_range(1, 3)) str_q.push_back(rand_digit());
      if (suffix) str_q.push_back(CH_F);
    end
    add_spaces(0, 2);
  endtask

  task automatic build_string(input gen_kind_t kind);
    int pos;
    str_q.delete();
    case (kind)
      GEN_CHAR: begin
        add_spaces(0, 3);
        str_q.push_back(rand_symbol());
        add_spaces(0, 3);
      end
      GEN_INT:    add_number(1'b0, 1'b0);
      GEN_FLOAT:  add_number(1'b1, 1'b1);
      GEN_DOUBLE: add_number(1'b1, 1'b0);
      GEN_SPACES: add_spaces(1, 4);
      GEN_BROKEN: begin
        // a well-formed number with one character swapped for any byte
        add_number(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        pos = $urandom_range(0, str_q.size() - 1);
        str_q[pos] = 8'($urandom_range(0, 255));
      end
      default: begin
        repeat ($urandom_range(1, 4)) str_q.push_back(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  function automatic gen_kind_t pick_kind();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 14) return GEN_CHAR;
    if (roll < 32) return GEN_INT;
    if (roll < 50) return GEN_FLOAT;
    if (roll < 68) return GEN_DOUBLE;
    if (roll < 76) return GEN_SPACES;
    if (roll < 88) return GEN_BROKEN;
    return GEN_NOISE;
  endfunction

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // sink side: random stalls on the class stream, with stall-free stretches
  // ---------------------------------------------------------------------------
  initial begin : sink_ctrl
    int stall_left;
    int calm_left;
    stall_left = 0;
    calm_left  = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 199) == 0) calm_left = $urandom_range(30, 120);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        stall_left = idle_len(calm_left > 0);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result check: every class transfer against the oldest due class
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (class_due_q.size() == 0) begin
        err_count++;
        if (err_count <= MaxReports)
          $display("[%0t] unexpected class transfer, tdata=%h", $realtime, m_tdata);
      end else begin
        if (m_tdata !== {5'b0, class_due_q[0]}) begin
          err_count++;
          if (err_count <= MaxReports)
            $display("[%0t] class mismatch: expected %0d, got tdata=%h",
                     $realtime, class_due_q[0], m_tdata);
        end
        if (class_due_q[0] <= CLS_DOUBLE) class_hits[class_due_q[0]]++;
        void'(class_due_q.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stim
    int rand_chars;
    err_count    = 0;
    chars_sent   = 0;
    strings_sent = 0;
    results_seen = 0;
    class_hits   = '{default: 0};
    src_burst    = 1'b0;
    scan_state   = ST_START;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed corner strings
    foreach (dir_tab[i])
      send_char(dir_tab[i].ch, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].cls);

    // random strings
    rand_chars = 0;
    while (rand_chars < RandomChars) begin
      if ($urandom_range(0, 5) == 0) src_burst = ~src_burst;
      build_string(pick_kind());
      foreach (str_q[i])
        send_char(str_q[i], i == str_q.size() - 1, 1'b0, CLS_NONE);
      rand_chars += str_q.size();
    end
    s_tvalid <= 1'b0;

    // drain, then let the two pipeline stages settle
    while (class_due_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (class_due_q.size() != 0) err_count++;

    $display("covered %0d strings in %0d characters, %0d class results checked",
             strings_sent, chars_sent, results_seen);
    $display("classes seen: none %0d, char %0d, int %0d, float %0d, double %0d",
             class_hits[0], class_hits[1], class_hits[2], class_hits[3], class_hits[4]);
    if (err_count == 0) begin
      $display("tb_literal_type_classifier: clean");
    end else begin
      $display("%0d mismatches in total", err_count);
      $display("tb_literal_type_classifier: errors");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------------
  initial begin
    #3000000;
    $display("watchdog expired with %0d classes outstanding", class_due_q.size());
    $display("tb_literal_type_classifier: errors");
    $finish;
  end

endmodule

>>> sim.f
hdl/ltc_pkg.sv
hdl/ltc_input_stage.sv
hdl/ltc_scanner.sv
hdl/ltc_output_stage.sv
hdl/literal_type_classifier.sv
hdl/ltc_checker.sv
bench/tb_literal_type_classifier.sv
